FILE: hdl/wmtm_pkg.sv
// Package for the sliding-window wind statistics core: item/result types,
// register map codes and fixed constants. No dependencies.
package wmtm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int PADDR_W        = 4;

    localparam logic [15:0] OVERRIDE_SPEED = 16'd50000;
    localparam int          LEN_RST        = 10;
    localparam logic [4:0]  REJ_RST        = 5'd2;

    localparam logic [1:0] REG_WINDOW_LEN    = 2'd0;
    localparam logic [1:0] REG_REJECT_COUNT  = 2'd1;
    localparam logic [1:0] REG_OVERRIDE_HOLD = 2'd2;

    typedef struct packed {
        logic [15:0] speed_sample;
        logic        sample_valid;
        logic        read_error;
    } item_t;

    typedef struct packed {
        logic signed [16:0] last_speed;
        logic [15:0]        window_mean;
        logic [15:0]        trimmed_mean;
        logic [15:0]        window_median;
        logic [15:0]        reported_speed;
    } result_t;

endpackage

FILE: hdl/wmtm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wmtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/window_mean_trimmed_median_core.sv
// Sliding-window wind-speed statistics core (mean, trimmed mean, median).
// Depends on wmtm_pkg and wmtm_ram.
//
//   channel   dir   handshake                       payload
//   item      in    item_valid / item_stall         item_t
//   result    out   result_valid / result_stall     result_t
//   config    in    APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// Each item runs a merge pass over the sorted-copy RAM, through the MRG_RD and
// MRG_PR states for each entry, then two divisions on one shared restoring
// divider, one bit a cycle.
// Reset, and any window_len write, clear the ring and sorted copy at once
// through per-entry valid bits; no clearing pass.
// A new item is taken while a finished result waits in the output register.
module window_mean_trimmed_median_core
    import wmtm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  item_t               item,
    input  logic                item_valid,
    output logic                item_stall,
    output result_t             result,
    output logic                result_valid,
    input  logic                result_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW     = $clog2(WINDOW_MAX);
    localparam int LW     = $clog2(WINDOW_MAX + 1);
    localparam int SB     = SAMPLE_BITS;
    localparam int SUMW   = SB + LW;
    localparam int CW     = $clog2(SUMW + 1);
    localparam int SDEPTH = 2 * (2 ** AW);
    localparam int LEN0   = (LEN_RST > WINDOW_MAX) ? WINDOW_MAX : LEN_RST;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RING    = 4'd1;
    localparam logic [3:0] S_MRG_RD  = 4'd2;
    localparam logic [3:0] S_MRG_PR  = 4'd3;
    localparam logic [3:0] S_MRG_END = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_OUT     = 4'd6;

    logic [3:0]            state_reg, state_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [4:0]            rej_reg, rej_next;
    logic                  ovr_reg, ovr_next;
    logic [AW-1:0]         slot_reg, slot_next;
    logic [WINDOW_MAX-1:0] ring_vld_reg, ring_vld_next;
    logic [SDEPTH-1:0]     srt_vld_reg, srt_vld_next;
    logic                  bank_reg, bank_next;
    logic [SUMW-1:0]       sum_reg, sum_next;
    logic [SUMW-1:0]       tsum_reg, tsum_next;
    item_t                 it_reg, it_next;
    logic [SB-1:0]         old_reg, old_next;
    logic [SB-1:0]         new_reg, new_next;
    logic [LW-1:0]         i_reg, i_next;
    logic [LW-1:0]         w_reg, w_next;
    logic                  del_reg, del_next;
    logic                  ins_reg, ins_next;
    logic [SB-1:0]         lo_reg, lo_next;
    logic [SB-1:0]         hi_reg, hi_next;
    logic [SUMW-1:0]       q_reg, q_next;
    logic [LW-1:0]         r_reg, r_next;
    logic [LW-1:0]         dvs_reg, dvs_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  phase_reg, phase_next;
    logic [15:0]           mean_reg, mean_next;
    result_t               res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  cfg_wr;
    logic [1:0]            cfg_idx;
    logic [6:0]            len_wval;
    logic [LW-1:0]         len_clamp;
    logic [LW-1:0]         half;
    logic [LW-1:0]         rej_c;
    logic [LW-1:0]         tdiv;
    logic [LW-1:0]         mid_hi;
    logic [LW-1:0]         mid_lo;
    logic [LW-1:0]         slot_inc;

    logic                  ring_we;
    logic [SB-1:0]         ring_wdata;
    logic [SB-1:0]         ring_rdata;
    logic [SB-1:0]         ring_val;
    logic                  srt_we;
    logic [AW:0]           srt_waddr;
    logic [AW:0]           srt_raddr;
    logic [SB-1:0]         srt_wdata;
    logic [SB-1:0]         srt_rdata;
    logic [SB-1:0]         srt_val;

    logic [LW:0]           trial;
    logic                  ge;
    logic [LW:0]           diff;
    logic [SB:0]           med_sum;
    logic [SB-1:0]         old_v;
    logic [SB-1:0]         new_v;

    wmtm_ram #(.WIDTH(SB), .DEPTH(2 ** AW)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (ring_wdata),
        .raddr (slot_reg),
        .rdata (ring_rdata)
    );

    wmtm_ram #(.WIDTH(SB), .DEPTH(SDEPTH)) u_sorted (
        .clk   (clk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    // Config port
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = paddr[3:2];
    assign len_wval = pwdata[6:0];

    always_comb
    begin
        if (len_wval == 7'd0)
        begin
            len_clamp = LW'(1);
        end
        else if (32'(len_wval) > 32'(WINDOW_MAX))
        begin
            len_clamp = LW'(WINDOW_MAX);
        end
        else
        begin
            len_clamp = LW'(len_wval);
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW_LEN:    prdata = 32'(len_reg);
            REG_REJECT_COUNT:  prdata = 32'(rej_reg);
            REG_OVERRIDE_HOLD: prdata = 32'(ovr_reg);
            default:           prdata = 32'd0;
        endcase
    end

    // Derived window quantities
    assign half     = (len_reg - LW'(1)) >> 1;
    assign rej_c    = ({{LW{1'b0}}, rej_reg} > {5'd0, half}) ? half : LW'(rej_reg);
    assign tdiv     = len_reg - (rej_c << 1);
    assign mid_hi   = len_reg >> 1;
    assign mid_lo   = len_reg[0] ? mid_hi : (mid_hi - LW'(1));
    assign slot_inc = LW'(slot_reg) + LW'(1);

    // Entries never written since the last clear read as zero
    assign ring_val  = ring_vld_reg[slot_reg] ? ring_rdata : '0;
    assign srt_raddr = {bank_reg, i_reg[AW-1:0]};
    assign srt_val   = srt_vld_reg[srt_raddr] ? srt_rdata : '0;
    assign old_v     = ring_val;
    assign new_v     = it_reg.sample_valid ? it_reg.speed_sample : ring_val;

    // Shared restoring divider step
    assign trial   = {r_reg, q_reg[SUMW-1]};
    assign ge      = trial >= {1'b0, dvs_reg};
    assign diff    = trial - {1'b0, dvs_reg};
    assign med_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    assign item_stall   = (state_reg != S_IDLE);
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        rej_next       = rej_reg;
        ovr_next       = ovr_reg;
        slot_next      = slot_reg;
        ring_vld_next  = ring_vld_reg;
        srt_vld_next   = srt_vld_reg;
        bank_next      = bank_reg;
        sum_next       = sum_reg;
        tsum_next      = tsum_reg;
        it_next        = it_reg;
        old_next       = old_reg;
        new_next       = new_reg;
        i_next         = i_reg;
        w_next         = w_reg;
        del_next       = del_reg;
        ins_next       = ins_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        mean_next      = mean_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & result_stall;
        ring_we        = 1'b0;
        ring_wdata     = it_reg.speed_sample;
        srt_we         = 1'b0;
        srt_wdata      = new_reg;
        srt_waddr      = {~bank_reg, w_reg[AW-1:0]};

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WINDOW_LEN:
                begin
                    len_next      = len_clamp;
                    slot_next     = '0;
                    ring_vld_next = '0;
                    srt_vld_next  = '0;
                    bank_next     = 1'b0;
                    sum_next      = '0;
                end
                REG_REJECT_COUNT:  rej_next = pwdata[4:0];
                REG_OVERRIDE_HOLD: ovr_next = pwdata[0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    it_next    = item;
                    state_next = S_RING;
                end
            end
            S_RING:
            begin
                if (it_reg.sample_valid)
                begin
                    ring_we                 = 1'b1;
                    ring_vld_next[slot_reg] = 1'b1;
                end
                old_next   = old_v;
                new_next   = new_v;
                sum_next   = sum_reg - SUMW'(old_v) + SUMW'(new_v);
                slot_next  = (slot_inc >= len_reg) ? '0 : slot_inc[AW-1:0];
                i_next     = '0;
                w_next     = '0;
                del_next   = 1'b0;
                ins_next   = 1'b0;
                tsum_next  = '0;
                state_next = S_MRG_RD;
            end
            S_MRG_RD:
            begin
                state_next = (i_reg == len_reg) ? S_MRG_END : S_MRG_PR;
            end
            S_MRG_PR:
            begin
                // drop one copy of the old value, insert the new one in order
                if (!del_reg && (srt_val == old_reg))
                begin
                    del_next   = 1'b1;
                    i_next     = i_reg + LW'(1);
                    state_next = S_MRG_RD;
                end
                else if (!ins_reg && (new_reg <= srt_val))
                begin
                    srt_we    = 1'b1;
                    srt_wdata = new_reg;
                    ins_next  = 1'b1;
                end
                else
                begin
                    srt_we     = 1'b1;
                    srt_wdata  = srt_val;
                    i_next     = i_reg + LW'(1);
                    state_next = S_MRG_RD;
                end
            end
            S_MRG_END:
            begin
                if (!ins_reg)
                begin
                    srt_we    = 1'b1;
                    srt_wdata = new_reg;
                    ins_next  = 1'b1;
                end
                q_next     = sum_reg;
                r_next     = '0;
                dvs_next   = len_reg;
                cnt_next   = CW'(SUMW);
                phase_next = 1'b0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    r_next   = ge ? diff[LW-1:0] : trial[LW-1:0];
                    q_next   = {q_reg[SUMW-2:0], ge};
                    cnt_next = cnt_reg - CW'(1);
                end
                else if (!phase_reg)
                begin
                    mean_next  = q_reg[15:0];
                    q_next     = tsum_reg;
                    r_next     = '0;
                    dvs_next   = tdiv;
                    cnt_next   = CW'(SUMW);
                    phase_next = 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next.last_speed     = it_reg.read_error ? 17'sh1FFFF
                                                                : signed'({1'b0, new_reg});
                    res_next.window_mean    = mean_reg;
                    res_next.trimmed_mean   = q_reg[15:0];
                    res_next.window_median  = med_sum[SB:1];
                    res_next.reported_speed = ovr_reg ? OVERRIDE_SPEED : mean_reg;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // every sorted write lands at w; trimmed sum and median taps follow it
        if (srt_we)
        begin
            srt_vld_next[srt_waddr] = 1'b1;
            w_next                  = w_reg + LW'(1);
            if ((w_reg >= rej_c) && (w_reg < (len_reg - rej_c)))
            begin
                tsum_next = tsum_reg + SUMW'(srt_wdata);
            end
            if (w_reg == mid_lo)
            begin
                lo_next = srt_wdata;
            end
            if (w_reg == mid_hi)
            begin
                hi_next = srt_wdata;
            end
        end
        if (state_reg == S_MRG_END)
        begin
            bank_next = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LW'(LEN0);
            rej_reg       <= REJ_RST;
            ovr_reg       <= 1'b0;
            slot_reg      <= '0;
            ring_vld_reg  <= '0;
            srt_vld_reg   <= '0;
            bank_reg      <= 1'b0;
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
            i_reg         <= '0;
            w_reg         <= '0;
            del_reg       <= 1'b0;
            ins_reg       <= 1'b0;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rej_reg       <= rej_next;
            ovr_reg       <= ovr_next;
            slot_reg      <= slot_next;
            ring_vld_reg  <= ring_vld_next;
            srt_vld_reg   <= srt_vld_next;
            bank_reg      <= bank_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
            i_reg         <= i_next;
            w_reg         <= w_next;
            del_reg       <= del_next;
            ins_reg       <= ins_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tsum_reg <= tsum_next;
        it_reg   <= it_next;
        old_reg  <= old_next;
        new_reg  <= new_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        dvs_reg  <= dvs_next;
        mean_reg <= mean_next;
        res_reg  <= res_next;
    end

    // merge pass must end with exactly len entries written
    a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MRG_END) |=> (w_reg == len_reg))
        else $error("sorted copy length mismatch after merge");

    // the old slot value is always present in the sorted copy
    a_old_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MRG_END) |-> del_reg)
        else $error("old sample not found in sorted copy");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg != '0) |-> (r_reg < dvs_reg))
        else $error("divider remainder out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && res_valid_reg && result_stall) |=> (state_reg == S_OUT))
        else $error("result overwritten while stalled");

endmodule
